// ===== rtl/itpa_pkg.sv =====
// Package for the integer-to-padded-ASCII block: item types, radix codes,
// controller states and the digit-to-character mapping.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package itpa_pkg;

  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned DIGIT_SLOTS   = 20;
  localparam int unsigned BCD_W         = DIGIT_SLOTS * 4;
  localparam int unsigned LEN_W         = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned STEP_W        = $clog2(VALUE_W);
  localparam int unsigned FIELD_W       = 7;
  localparam int unsigned ROOM_CAP      = 64;
  localparam int unsigned WIDTH_CAP_DEF = 64;

  localparam logic [1:0] RADIX_DEC    = 2'd0;
  localparam logic [1:0] RADIX_HEX_LO = 2'd1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         radix_mode;
    logic               pad_with_zero;
    logic [FIELD_W-1:0] min_width;
    logic [FIELD_W-1:0] room;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // Commands from the controller to the digit register.
  typedef struct packed {
    logic load;
    logic hex;
    logic shift;
  } dg_ctrl_t;

  // Status from the digit register to the controller.
  typedef struct packed {
    logic             ready;
    logic [LEN_W-1:0] len;
    logic [3:0]       top;
  } dg_stat_t;

  typedef enum logic [1:0] {
    DG_IDLE,
    DG_DABBLE,
    DG_NORM,
    DG_READY
  } dg_state_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } top_state_e;

  // Maps one digit to its ASCII character. Radix code three reads as upper-case hex.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] mode);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else if (mode == RADIX_HEX_LO) begin
      c = CHAR_LO_A + {4'b0, d - 4'd10};
    end else begin
      c = CHAR_UP_A + {4'b0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_padded_ascii.sv =====
// Top level of the integer-to-padded-ASCII block: command port, sequencing of
// conversion and sizing, and the character emitter.
// Depends on itpa_pkg and itpa_digits.
//
//   channel   direction  handshake              payload
//   command   in         start && !busy         in_i  (in_item_t)
//   result    out        valid_o, one cycle     out_o (out_item_t)
//
// A decimal item is shifted through the double-dabble shift register, one bit
// per cycle; hex skips this. Leading zero digits then leave the digit register
// one per cycle (up to 19 digits), and the characters follow one per cycle, up
// to 64. The next item can be accepted while busy is low. The bit-serial
// dabble loop and the one-character-per-cycle emitter set the length of a run.
// Reset is asynchronous and returns the block to idle with no run pending.
// The receiver cannot stall: each character stands on the ports for one cycle.
// An item with no room produces no characters and leaves the block idle.
`default_nettype none

module integer_to_padded_ascii
  import itpa_pkg::*;
#(
  parameter int unsigned WIDTH_CAP = WIDTH_CAP_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_i,
  output logic          valid_o,
  output out_item_t     out_o
);

  // Wide enough for the saturated minimum width and for the 7-bit field.
  localparam int unsigned WW = ($clog2(WIDTH_CAP + 1) > FIELD_W) ?
                               $clog2(WIDTH_CAP + 1) : FIELD_W;

  top_state_e         st_q, st_d;
  logic [1:0]         mode_q, mode_d;
  logic               padz_q, padz_d;
  logic [WW-1:0]      width_q, width_d;
  logic [FIELD_W-1:0] room_q, room_d;
  logic [WW-1:0]      pad_cnt_q, pad_cnt_d;
  logic [FIELD_W-1:0] rem_q, rem_d;

  logic               accept;
  logic [WW-1:0]      width_in;
  logic [FIELD_W-1:0] room_in;
  logic [WW-1:0]      len_ext;
  logic [WW-1:0]      pads;
  logic [WW:0]        run_len;
  dg_ctrl_t           dg_ctrl;
  dg_stat_t           dg_stat;

  assign accept = start && !busy;

  // Saturate the command fields: a minimum width above WIDTH_CAP is WIDTH_CAP,
  // and room above the cap means "at least the cap".
  assign width_in = (WW'(in_i.min_width) > WW'(WIDTH_CAP)) ? WW'(WIDTH_CAP)
                                                           : WW'(in_i.min_width);
  assign room_in  = (in_i.room > FIELD_W'(ROOM_CAP)) ? FIELD_W'(ROOM_CAP) : in_i.room;

  // Sizing: pads fill up to the minimum width, and the run is cut to the room.
  assign len_ext = WW'(dg_stat.len);
  assign pads    = (width_q > len_ext) ? (width_q - len_ext) : '0;
  assign run_len = {1'b0, pads} + {1'b0, len_ext};

  always_comb begin
    st_d      = st_q;
    mode_d    = mode_q;
    padz_d    = padz_q;
    width_d   = width_q;
    room_d    = room_q;
    pad_cnt_d = pad_cnt_q;
    rem_d     = rem_q;
    dg_ctrl   = '0;
    valid_o   = 1'b0;
    out_o     = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept && room_in != '0) begin
          mode_d       = in_i.radix_mode;
          padz_d       = in_i.pad_with_zero;
          width_d      = width_in;
          room_d       = room_in;
          dg_ctrl.load = 1'b1;
          dg_ctrl.hex  = (in_i.radix_mode != RADIX_DEC);
          st_d         = ST_CONV;
        end
      end
      ST_CONV: begin
        if (dg_stat.ready) begin
          st_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        pad_cnt_d = pads;
        if (run_len > (WW+1)'(room_q)) begin
          rem_d = room_q;
        end else begin
          rem_d = FIELD_W'(run_len);
        end
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        valid_o         = 1'b1;
        out_o.last_char = (rem_q == FIELD_W'(1));
        if (pad_cnt_q != '0) begin
          out_o.out_char = padz_q ? CHAR_ZERO : CHAR_SPACE;
          pad_cnt_d      = pad_cnt_q - WW'(1);
        end else begin
          out_o.out_char = digit_char(dg_stat.top, mode_q);
          dg_ctrl.shift  = 1'b1;
        end
        rem_d = rem_q - FIELD_W'(1);
        if (rem_q == FIELD_W'(1)) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      pad_cnt_q <= '0;
      rem_q     <= '0;
    end else begin
      st_q      <= st_d;
      pad_cnt_q <= pad_cnt_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    padz_q  <= padz_d;
    width_q <= width_d;
    room_q  <= room_d;
  end

  assign busy = (st_q != ST_IDLE);

  itpa_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dg_ctrl),
    .value_i (in_i.value),
    .stat_o  (dg_stat)
  );

  // A run ends with exactly one marked character and nothing directly after it.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.last_char |=> !valid_o)
    else $error("character follows the end of a run");

  // Inside a run the characters come on consecutive cycles.
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.last_char |=> valid_o)
    else $error("run broken before its last character");

  // An accepted item with room keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && room_in != '0 |=> busy)
    else $error("accepted item dropped");

  // Decimal digits out of the dabble register are always proper BCD.
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && pad_cnt_q == '0 && mode_q == RADIX_DEC |-> dg_stat.top < 4'd10)
    else $error("decimal digit out of range");

endmodule

`default_nettype wire

// ===== rtl/itpa_digits.sv =====
// Digit register: bit-serial double-dabble conversion to BCD, or a direct hex
// load, then removal of leading zero digits one digit per cycle.
// Depends on itpa_pkg.
`default_nettype none

module itpa_digits
  import itpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dg_ctrl_t           ctrl_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output dg_stat_t                stat_o
);

  dg_state_e          st_q, st_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [LEN_W-1:0]   len_q, len_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    st_d   = st_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    len_d  = len_q;
    if (ctrl_i.load) begin
      bin_d  = value_i;
      step_d = '0;
      len_d  = LEN_W'(DIGIT_SLOTS);
      if (ctrl_i.hex) begin
        bcd_d = {{(BCD_W-VALUE_W){1'b0}}, value_i};
        st_d  = DG_NORM;
      end else begin
        bcd_d = '0;
        st_d  = DG_DABBLE;
      end
    end else begin
      unique case (st_q)
        DG_IDLE: begin
        end
        DG_DABBLE: begin
          bcd_d  = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
          bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
          step_d = step_q + STEP_W'(1);
          if (step_q == STEP_W'(VALUE_W - 1)) begin
            st_d = DG_NORM;
          end
        end
        DG_NORM: begin
          if (bcd_q[BCD_W-1 -: 4] == 4'd0 && len_q > LEN_W'(1)) begin
            bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
            len_d = len_q - LEN_W'(1);
          end else begin
            st_d = DG_READY;
          end
        end
        DG_READY: begin
          if (ctrl_i.shift) begin
            bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          end
        end
        default: st_d = DG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DG_IDLE;
      step_q <= '0;
      len_q  <= LEN_W'(DIGIT_SLOTS);
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.ready = (st_q == DG_READY);
  assign stat_o.len   = len_q;
  assign stat_o.top   = bcd_q[BCD_W-1 -: 4];

endmodule

`default_nettype wire
